// File: sv/segment_box_clip_fractions_top_assert.svh
// Assertion macros used by the top RTL file of the segment box clip block.
`ifndef SEGMENT_BOX_CLIP_FRACTIONS_TOP_ASSERT_SVH
`define SEGMENT_BOX_CLIP_FRACTIONS_TOP_ASSERT_SVH

// Checks a condition at every clock edge outside of reset.
`define SBCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in the next cycle follows from a condition now.
`define SBCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/sbcf_pkg.sv
package sbcf_pkg;

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

// File: sv/sbcf_if.sv
interface sbcf_in_if #(
  parameter int unsigned COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] box_min_x;
  logic signed [COORD_BITS-1:0] box_min_y;
  logic signed [COORD_BITS-1:0] box_max_x;
  logic signed [COORD_BITS-1:0] box_max_y;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (
    output valid, box_min_x, box_min_y, box_max_x, box_max_y,
    output start_x, start_y, end_x, end_y,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_max_x, box_max_y,
    input  start_x, start_y, end_x, end_y,
    output ready
  );
endinterface

interface sbcf_out_if #(
  parameter int unsigned FRACTION_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [FRACTION_BITS:0] near_frac;
  logic [FRACTION_BITS:0] far_frac;

  modport source (output valid, hit, near_frac, far_frac, input ready);
  modport sink (input valid, hit, near_frac, far_frac, output ready);
endinterface

// File: sv/sbcf_udiv_pipe.sv
module sbcf_udiv_pipe #(
  parameter int unsigned QW   = 16,
  parameter int unsigned DENW = 16,
  parameter int unsigned SW   = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbcf_pkg::pipe_ctl_t ctl_i,
  input  logic [DENW-1:0]     rem_i,
  input  logic [QW-1:0]       low_i,
  input  logic [DENW-1:0]     den_i,
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output logic [QW-1:0]       quo_o,
  output logic [DENW-1:0]     rem_o,
  output logic [DENW-1:0]     den_o,
  output logic [SW-1:0]       side_o
);

  logic            vld_q  [QW];
  logic [DENW-1:0] rem_q  [QW];
  logic [QW-1:0]   quo_q  [QW];
  logic [QW-1:0]   low_q  [QW];
  logic [DENW-1:0] den_q  [QW];
  logic [SW-1:0]   side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic            vp;
    logic [DENW-1:0] rp;
    logic [DENW-1:0] dp;
    logic [QW-1:0]   qp;
    logic [QW-1:0]   lp;
    logic [SW-1:0]   sp;
    logic [DENW:0]   r2;
    logic            ge;

    if (k == 0) begin : g_first
      assign vp = ctl_i.valid;
      assign rp = rem_i;
      assign dp = den_i;
      assign qp = '0;
      assign lp = low_i;
      assign sp = side_i;
    end else begin : g_next
      assign vp = vld_q[k-1];
      assign rp = rem_q[k-1];
      assign dp = den_q[k-1];
      assign qp = quo_q[k-1];
      assign lp = low_q[k-1];
      assign sp = side_q[k-1];
    end

    assign r2 = {rp, lp[QW-1]};
    assign ge = r2 >= {1'b0, dp};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[k] <= vp;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[k]  <= ge ? DENW'(r2 - {1'b0, dp}) : r2[DENW-1:0];
        quo_q[k]  <= QW'({qp, ge});
        low_q[k]  <= lp << 1;
        den_q[k]  <= dp;
        side_q[k] <= sp;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign rem_o   = rem_q[QW-1];
  assign den_o   = den_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// File: sv/sbcf_isqrt_pipe.sv
module sbcf_isqrt_pipe #(
  parameter int unsigned RW = 16,
  parameter int unsigned SW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbcf_pkg::pipe_ctl_t ctl_i,
  input  logic [2*RW-1:0]     rad_i,
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output logic [RW-1:0]       root_o,
  output logic [SW-1:0]       side_o
);

  localparam int unsigned RMW = RW + 3;

  logic            vld_q  [RW];
  logic [RMW-1:0]  rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] rad_q  [RW];
  logic [SW-1:0]   side_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            vp;
    logic [RMW-1:0]  remp;
    logic [RW-1:0]   rootp;
    logic [2*RW-1:0] radp;
    logic [SW-1:0]   sp;
    logic [RMW-1:0]  r4;
    logic [RMW-1:0]  trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign vp    = ctl_i.valid;
      assign remp  = '0;
      assign rootp = '0;
      assign radp  = rad_i;
      assign sp    = side_i;
    end else begin : g_next
      assign vp    = vld_q[k-1];
      assign remp  = rem_q[k-1];
      assign rootp = root_q[k-1];
      assign radp  = rad_q[k-1];
      assign sp    = side_q[k-1];
    end

    assign r4    = {remp[RMW-3:0], radp[2*RW-1 -: 2]};
    assign trial = RMW'({rootp, 2'b01});
    assign ge    = r4 >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[k] <= vp;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[k]  <= ge ? (r4 - trial) : r4;
        root_q[k] <= RW'({rootp, ge});
        rad_q[k]  <= radp << 2;
        side_q[k] <= sp;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

// File: sv/segment_box_clip_fractions_top.sv
// Clips a line segment against an axis-aligned box and returns hit plus entry and exit
// fractions of the segment length in unsigned Q1.FRACTION_BITS. The block takes one
// transaction per cycle while the output is not stalled and returns results in order; the
// path runs through the bit-per-stage divider for the line heights, the bit-per-stage divider
// for the squared distance ratio, and the bit-per-stage square root.
// A stall on the result side freezes the whole pipeline, so input is refused exactly while
// a finished result waits at the output and is not taken.
`include "segment_box_clip_fractions_top_assert.svh"

module segment_box_clip_fractions_top #(
  parameter int unsigned COORD_BITS    = 24,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbcf_in_if.sink    in_i,
  sbcf_out_if.source out_o
);

  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned DW  = CW + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned LW  = 2 * DW + 1;
  localparam int unsigned YW  = DW + 2;
  localparam int unsigned FW  = FRACTION_BITS;
  localparam int unsigned OW  = FW + 1;
  localparam int unsigned QW2 = 2 * FW;
  localparam logic [OW-1:0] OneFrac = {1'b1, {FW{1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bminy;
    logic signed [CW-1:0] bmaxy;
    logic signed [CW-1:0] lox;
    logic signed [CW-1:0] hix;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic                 neglo;
    logic                 dxz;
    logic                 miss;
    logic                 xlt;
    logic                 xgt;
  } ys_t;

  function automatic logic [DW-1:0] diff_f(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return {a[CW-1], a} - {b[CW-1], b};
  endfunction

  function automatic logic [DW-1:0] mag_f(input logic [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : v;
  endfunction

  logic en;
  logic out_vld_q;
  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // Stage 1: edge runs and x clipping.
  logic signed [CW-1:0] ax, ay, bx, by, lo_xs, hi_xs, lox_c, hix_c;
  logic                 edge_run;
  assign ax       = in_i.start_x;
  assign ay       = in_i.start_y;
  assign bx       = in_i.end_x;
  assign by       = in_i.end_y;
  assign lo_xs    = (ax < bx) ? ax : bx;
  assign hi_xs    = (ax > bx) ? ax : bx;
  assign lox_c    = (in_i.box_min_x > lo_xs) ? in_i.box_min_x : lo_xs;
  assign hix_c    = (in_i.box_max_x < hi_xs) ? in_i.box_max_x : hi_xs;
  assign edge_run = ((ax == bx) && ((ax == in_i.box_min_x) || (ax == in_i.box_max_x))) ||
                    ((ay == by) && ((ay == in_i.box_min_y) || (ay == in_i.box_max_y)));

  logic v1_q;
  ys_t  ys1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ys1_q.ax    <= ax;
      ys1_q.ay    <= ay;
      ys1_q.by    <= by;
      ys1_q.bminy <= in_i.box_min_y;
      ys1_q.bmaxy <= in_i.box_max_y;
      ys1_q.lox   <= lox_c;
      ys1_q.hix   <= hix_c;
      ys1_q.dx    <= diff_f(bx, ax);
      ys1_q.dy    <= diff_f(by, ay);
      ys1_q.neglo <= 1'b0;
      ys1_q.dxz   <= ax == bx;
      ys1_q.miss  <= edge_run || (lox_c > hix_c);
      ys1_q.xlt   <= ax < bx;
      ys1_q.xgt   <= ax > bx;
    end
  end

  // Stage 2: products for the line heights at both clipped x values.
  logic [DW-1:0] tlo_c, thi_c, mdy_c;
  assign tlo_c = diff_f(ys1_q.lox, ys1_q.ax);
  assign thi_c = diff_f(ys1_q.hix, ys1_q.ax);
  assign mdy_c = mag_f(ys1_q.dy);

  ys_t ys2_d;

  always_comb begin
    ys2_d       = ys1_q;
    ys2_d.neglo = ys1_q.dy[DW-1] ^ tlo_c[DW-1] ^ ys1_q.dx[DW-1];
  end

  logic          v2_q;
  logic [PW-1:0] plo2_q, phi2_q;
  logic [DW-1:0] den2_q;
  logic          neghi2_q;
  ys_t           ys2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      plo2_q   <= PW'(mdy_c) * PW'(mag_f(tlo_c));
      phi2_q   <= PW'(mdy_c) * PW'(mag_f(thi_c));
      den2_q   <= ys1_q.dxz ? DW'(1) : mag_f(ys1_q.dx);
      neghi2_q <= ys1_q.dy[DW-1] ^ thi_c[DW-1] ^ ys1_q.dx[DW-1];
      ys2_q    <= ys2_d;
    end
  end

  sbcf_pkg::pipe_ctl_t ctl_line;
  assign ctl_line.en    = en;
  assign ctl_line.valid = v2_q;

  logic                  lo_vld, hi_vld, hi_neg;
  logic [DW-1:0]         lo_quo, lo_rem, lo_den, hi_quo, hi_rem, hi_den;
  logic [$bits(ys_t)-1:0] lo_side;

  sbcf_udiv_pipe #(.QW(DW), .DENW(DW), .SW($bits(ys_t))) u_div_lo (
    .clk_i, .rst_ni, .ctl_i(ctl_line),
    .rem_i(plo2_q[PW-1:DW]), .low_i(plo2_q[DW-1:0]), .den_i(den2_q), .side_i(ys2_q),
    .valid_o(lo_vld), .quo_o(lo_quo), .rem_o(lo_rem), .den_o(lo_den), .side_o(lo_side)
  );

  sbcf_udiv_pipe #(.QW(DW), .DENW(DW), .SW(1)) u_div_hi (
    .clk_i, .rst_ni, .ctl_i(ctl_line),
    .rem_i(phi2_q[PW-1:DW]), .low_i(phi2_q[DW-1:0]), .den_i(den2_q), .side_i(neghi2_q),
    .valid_o(hi_vld), .quo_o(hi_quo), .rem_o(hi_rem), .den_o(hi_den), .side_o(hi_neg)
  );

  // Stage 3: round the quotients and form the line heights.
  ys_t                  ys3_c;
  logic [DW:0]          qlo_c, qhi_c;
  logic signed [YW-1:0] ay_e, by_e, ylo_c, yhi_c;
  assign ys3_c = ys_t'(lo_side);
  assign qlo_c = {1'b0, lo_quo} + {{DW{1'b0}}, lo_rem >= (lo_den - lo_rem)};
  assign qhi_c = {1'b0, hi_quo} + {{DW{1'b0}}, hi_rem >= (hi_den - hi_rem)};
  assign ay_e  = {{(YW-CW){ys3_c.ay[CW-1]}}, ys3_c.ay};
  assign by_e  = {{(YW-CW){ys3_c.by[CW-1]}}, ys3_c.by};

  always_comb begin
    if (ys3_c.dxz) begin
      ylo_c = ay_e;
      yhi_c = by_e;
    end else begin
      ylo_c = ys3_c.neglo ? ay_e - {1'b0, qlo_c} : ay_e + {1'b0, qlo_c};
      yhi_c = hi_neg ? ay_e - {1'b0, qhi_c} : ay_e + {1'b0, qhi_c};
    end
  end

  logic                 v3_q;
  logic signed [YW-1:0] ylo3_q, yhi3_q;
  ys_t                  ys3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= lo_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ylo3_q <= ylo_c;
      yhi3_q <= yhi_c;
      ys3_q  <= ys3_c;
    end
  end

  // Stage 4: order the heights and clip them to the box in y.
  logic signed [YW-1:0] ymin_c, ymax_c, bminy_e, bmaxy_e, loy_c, hiy_c;
  ys_t                  ys4_d;
  assign ymin_c  = (ylo3_q < yhi3_q) ? ylo3_q : yhi3_q;
  assign ymax_c  = (ylo3_q < yhi3_q) ? yhi3_q : ylo3_q;
  assign bminy_e = {{(YW-CW){ys3_q.bminy[CW-1]}}, ys3_q.bminy};
  assign bmaxy_e = {{(YW-CW){ys3_q.bmaxy[CW-1]}}, ys3_q.bmaxy};
  assign loy_c   = (bminy_e > ymin_c) ? bminy_e : ymin_c;
  assign hiy_c   = (bmaxy_e < ymax_c) ? bmaxy_e : ymax_c;

  always_comb begin
    ys4_d      = ys3_q;
    ys4_d.miss = ys3_q.miss || (loy_c > hiy_c);
  end

  logic                 v4_q;
  logic signed [CW-1:0] loy4_q, hiy4_q;
  ys_t                  ys4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      loy4_q <= loy_c[CW-1:0];
      hiy4_q <= hiy_c[CW-1:0];
      ys4_q  <= ys4_d;
    end
  end

  // Stage 5: entry and exit points and their offsets from the start point.
  logic signed [CW-1:0] ex_c, ey_c, xx_c, xy_c;
  assign ex_c = ys4_q.xlt ? ys4_q.lox : ys4_q.hix;
  assign xx_c = ys4_q.xgt ? ys4_q.lox : ys4_q.hix;
  assign ey_c = (ys4_q.ay < ys4_q.by) ? loy4_q : hiy4_q;
  assign xy_c = (ys4_q.ay > ys4_q.by) ? loy4_q : hiy4_q;

  logic          v5_q, miss5_q;
  logic [DW-1:0] mdx5_q, mdy5_q, medx5_q, medy5_q, mxdx5_q, mxdy5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      miss5_q <= ys4_q.miss;
      mdx5_q  <= mag_f(ys4_q.dx);
      mdy5_q  <= mag_f(ys4_q.dy);
      medx5_q <= mag_f(diff_f(ex_c, ys4_q.ax));
      medy5_q <= mag_f(diff_f(ey_c, ys4_q.ay));
      mxdx5_q <= mag_f(diff_f(xx_c, ys4_q.ax));
      mxdy5_q <= mag_f(diff_f(xy_c, ys4_q.ay));
    end
  end

  // Stage 6: squares.
  logic          v6_q, miss6_q;
  logic [PW-1:0] sdx6_q, sdy6_q, sedx6_q, sedy6_q, sxdx6_q, sxdy6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      miss6_q <= miss5_q;
      sdx6_q  <= PW'(mdx5_q) * PW'(mdx5_q);
      sdy6_q  <= PW'(mdy5_q) * PW'(mdy5_q);
      sedx6_q <= PW'(medx5_q) * PW'(medx5_q);
      sedy6_q <= PW'(medy5_q) * PW'(medy5_q);
      sxdx6_q <= PW'(mxdx5_q) * PW'(mxdx5_q);
      sxdy6_q <= PW'(mxdy5_q) * PW'(mxdy5_q);
    end
  end

  // Stage 7: squared lengths.
  logic          v7_q, miss7_q;
  logic [LW-1:0] d2e7_q, d2x7_q, l27_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (en) begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      miss7_q <= miss6_q;
      d2e7_q  <= LW'(sedx6_q) + LW'(sedy6_q);
      d2x7_q  <= LW'(sxdx6_q) + LW'(sxdy6_q);
      l27_q   <= LW'(sdx6_q) + LW'(sdy6_q);
    end
  end

  // Stage 8: saturation and divider operands. A distance at least a nonzero length gives 1.0.
  logic l2z_c, sate_c, satx_c;
  assign l2z_c  = l27_q == '0;
  assign sate_c = d2e7_q >= l27_q;
  assign satx_c = d2x7_q >= l27_q;

  logic          v8_q, miss8_q, l2z8_q, sate8_q, satx8_q;
  logic [LW-1:0] reme8_q, remx8_q, den8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else if (en) begin
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      miss8_q <= miss7_q;
      l2z8_q  <= l2z_c;
      sate8_q <= sate_c;
      satx8_q <= satx_c;
      reme8_q <= (l2z_c || sate_c) ? '0 : d2e7_q;
      remx8_q <= (l2z_c || satx_c) ? '0 : d2x7_q;
      den8_q  <= l2z_c ? LW'(1) : l27_q;
    end
  end

  sbcf_pkg::pipe_ctl_t ctl_frac;
  assign ctl_frac.en    = en;
  assign ctl_frac.valid = v8_q;

  logic           fe_vld;
  logic [QW2-1:0] fe_quo, fx_quo;
  logic [2:0]     fe_side;
  logic           fx_side;

  sbcf_udiv_pipe #(.QW(QW2), .DENW(LW), .SW(3)) u_div_entry (
    .clk_i, .rst_ni, .ctl_i(ctl_frac),
    .rem_i(reme8_q), .low_i('0), .den_i(den8_q), .side_i({miss8_q, l2z8_q, sate8_q}),
    .valid_o(fe_vld), .quo_o(fe_quo), .rem_o(), .den_o(), .side_o(fe_side)
  );

  sbcf_udiv_pipe #(.QW(QW2), .DENW(LW), .SW(1)) u_div_exit (
    .clk_i, .rst_ni, .ctl_i(ctl_frac),
    .rem_i(remx8_q), .low_i('0), .den_i(den8_q), .side_i(satx8_q),
    .valid_o(), .quo_o(fx_quo), .rem_o(), .den_o(), .side_o(fx_side)
  );

  sbcf_pkg::pipe_ctl_t ctl_sqrt;
  assign ctl_sqrt.en    = en;
  assign ctl_sqrt.valid = fe_vld;

  logic          sq_vld;
  logic [FW-1:0] re_root, rx_root;
  logic [2:0]    re_side;
  logic          rx_side;

  sbcf_isqrt_pipe #(.RW(FW), .SW(3)) u_sqrt_entry (
    .clk_i, .rst_ni, .ctl_i(ctl_sqrt),
    .rad_i(fe_quo), .side_i(fe_side),
    .valid_o(sq_vld), .root_o(re_root), .side_o(re_side)
  );

  sbcf_isqrt_pipe #(.RW(FW), .SW(1)) u_sqrt_exit (
    .clk_i, .rst_ni, .ctl_i(ctl_sqrt),
    .rad_i(fx_quo), .side_i(fx_side),
    .valid_o(), .root_o(rx_root), .side_o(rx_side)
  );

  // Output register. Side bits of the entry lane: miss, zero length, saturated.
  logic          out_hit_q;
  logic [OW-1:0] out_entry_q, out_exit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_hit_q <= !re_side[2];
      if (re_side[2] || re_side[1]) begin
        out_entry_q <= '0;
        out_exit_q  <= '0;
      end else begin
        out_entry_q <= re_side[0] ? OneFrac : {1'b0, re_root};
        out_exit_q  <= rx_side ? OneFrac : {1'b0, rx_root};
      end
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.hit       = out_hit_q;
  assign out_o.near_frac = out_entry_q;
  assign out_o.far_frac  = out_exit_q;

  `SBCF_ASSERT(a_miss_has_zero_fractions, !out_vld_q || out_hit_q || (out_entry_q == '0 && out_exit_q == '0), "miss with nonzero fraction")
  `SBCF_ASSERT(a_fraction_at_most_one, !out_vld_q || (out_entry_q <= OneFrac && out_exit_q <= OneFrac), "fraction above one")
  `SBCF_ASSERT(a_line_lanes_aligned, lo_vld == hi_vld, "line height dividers out of step")
  `SBCF_ASSERT(a_stall_blocks_input, !(out_vld_q && !out_o.ready) || !in_i.ready, "input taken while output stalled")
  `SBCF_ASSERT_NEXT(a_freeze_on_stall, !en, $stable(lo_vld) && $stable(fe_vld), "pipeline moved while stalled")

endmodule
